FILE: design/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg: shared types and codes for the minimum covering window block
// Item and result payload structs, item kinds, status codes, and the command
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam logic [1:0] KIND_TARGET = 2'd0;
  localparam logic [1:0] KIND_SOURCE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_LATE     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  best_start;
    logic [10:0] best_len;
    logic [1:0]  status;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;        // capture the accepted item
    logic decode;       // capture the status code of the item
    logic src_start;    // append the source byte and read its need count
    logic clear;        // restart the search
    logic tgt_upd;      // raise the need count of a target byte
    logic src_upd;      // lower the need count of a source byte
    logic record;       // note the current window if it is the shortest
    logic need_rd_out;  // read the need count of the byte leaving the window
    logic shr_upd;      // restore the count of the leaving byte, advance left
    logic load_out;     // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       begun;
    logic       tgt_full;
    logic       src_full;
    logic       shrink;
  } sts_t;

endpackage

FILE: design/mcw_ctrl.sv
// ----------------------------------------------------------------------------
// mcw_ctrl: sequencer for the minimum covering window block
// Walks each item through decode, count update and the shrink loop, and owns
// the handshake flags of both channels.
// ----------------------------------------------------------------------------
module mcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  output logic          result_valid,
  input  logic          result_ready,
  input  mcw_pkg::sts_t sts,
  output mcw_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_TGT    = 3'd2;
  localparam logic [2:0] S_SRC    = 3'd3;
  localparam logic [2:0] S_CHK    = 3'd4;
  localparam logic [2:0] S_WIN    = 3'd5;
  localparam logic [2:0] S_SHR    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       result_valid_next;
  logic       out_free;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    state_next        = state;
    cmd               = '0;
    result_valid_next = result_valid && !result_ready;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_OUT;
        case (sts.kind)
          mcw_pkg::KIND_TARGET: begin
            if (!sts.begun && !sts.tgt_full) begin
              state_next = S_TGT;
            end
          end
          mcw_pkg::KIND_SOURCE: begin
            if (!sts.src_full) begin
              cmd.src_start = 1'b1;
              state_next    = S_SRC;
            end
          end
          mcw_pkg::KIND_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_TGT: begin
        cmd.tgt_upd = 1'b1;
        state_next  = S_OUT;
      end
      S_SRC: begin
        cmd.src_upd = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (sts.shrink) begin
          cmd.record = 1'b1;
          state_next = S_WIN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WIN: begin
        cmd.need_rd_out = 1'b1;
        state_next      = S_SHR;
      end
      S_SHR: begin
        cmd.shr_upd = 1'b1;
        state_next  = S_CHK;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

FILE: design/mcw_dpath.sv
// ----------------------------------------------------------------------------
// mcw_dpath: storage and arithmetic of the minimum covering window block
// Holds the need count memory with its valid bits, the window buffer, the
// search registers and the result register.
// ----------------------------------------------------------------------------
module mcw_dpath #(
  parameter int MAX_LEN  = 1024,
  parameter int ALPHABET = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  mcw_pkg::item_t  item,
  input  mcw_pkg::cmd_t   cmd,
  output mcw_pkg::sts_t   sts,
  output mcw_pkg::result_t result
);

  localparam int SW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = PW + 1;
  localparam logic [PW-1:0] LIMIT = PW'(MAX_LEN);

  // Symbol reduction table, built at elaboration.
  logic [SW-1:0] sym_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign sym_lut[g] = SW'(g % ALPHABET);
  end

  logic [1:0]    item_kind;
  logic [SW-1:0] item_sym;
  logic [1:0]    status;

  logic [PW-1:0] target_len;
  logic [PW-1:0] matched;
  logic [PW-1:0] left_pos;
  logic [PW-1:0] next_pos;
  logic [PW-1:0] shortest_len;
  logic [PW-1:0] shortest_start;
  logic          have_found;
  logic          source_begun;

  logic [CW-1:0] need_mem [ALPHABET];
  logic [ALPHABET-1:0] need_vld;
  logic [SW-1:0] need_raddr;
  logic [CW-1:0] need_rdata;
  logic          need_rvalid;
  logic [CW-1:0] need_val;
  logic          need_we;
  logic [SW-1:0] need_waddr;
  logic [CW-1:0] need_wdata;

  logic [SW-1:0] win_mem [MAX_LEN];
  logic [SW-1:0] win_rdata;

  logic [PW-1:0] cur_len;
  logic          tgt_full;
  logic          src_full;

  assign tgt_full = (target_len >= LIMIT);
  assign src_full = (next_pos >= LIMIT);
  assign cur_len  = next_pos - left_pos;

  assign sts.kind     = item_kind;
  assign sts.begun    = source_begun;
  assign sts.tgt_full = tgt_full;
  assign sts.src_full = src_full;
  assign sts.shrink   = (target_len != '0) && (matched == target_len) &&
                        (left_pos < next_pos);

  // A count whose valid bit is clear has not been written since reset or the
  // last clear and reads as zero.
  assign need_val   = need_rvalid ? need_rdata : '0;
  assign need_raddr = cmd.need_rd_out ? win_rdata : item_sym;

  always_comb begin
    need_we    = 1'b0;
    need_waddr = item_sym;
    need_wdata = need_val + CW'(1);
    if (cmd.tgt_upd) begin
      need_we = 1'b1;
    end else if (cmd.src_upd) begin
      need_we    = 1'b1;
      need_wdata = need_val - CW'(1);
    end else if (cmd.shr_upd) begin
      need_we    = 1'b1;
      need_waddr = win_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (need_we) begin
      need_mem[need_waddr] <= need_wdata;
    end
    need_rdata <= need_mem[need_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.src_start) begin
      win_mem[next_pos[AW-1:0]] <= item_sym;
    end
    win_rdata <= win_mem[left_pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      need_vld    <= '0;
      need_rvalid <= 1'b0;
    end else begin
      if (need_we) begin
        need_vld[need_waddr] <= 1'b1;
      end
      need_rvalid <= need_vld[need_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_kind <= item.kind;
      item_sym  <= sym_lut[item.symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      status <= mcw_pkg::STATUS_OK;
      if (item_kind == mcw_pkg::KIND_TARGET) begin
        if (source_begun) begin
          status <= mcw_pkg::STATUS_LATE;
        end else if (tgt_full) begin
          status <= mcw_pkg::STATUS_OVERFLOW;
        end
      end else if (item_kind == mcw_pkg::KIND_SOURCE && src_full) begin
        status <= mcw_pkg::STATUS_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      target_len     <= '0;
      matched        <= '0;
      left_pos       <= '0;
      next_pos       <= '0;
      shortest_len   <= '0;
      shortest_start <= '0;
      have_found     <= 1'b0;
      source_begun   <= 1'b0;
    end else begin
      if (cmd.tgt_upd) begin
        target_len <= target_len + PW'(1);
      end
      if (cmd.src_start) begin
        next_pos     <= next_pos + PW'(1);
        source_begun <= 1'b1;
      end
      // The count before the decrement was at least one.
      if (cmd.src_upd && !need_val[CW-1] && need_val != '0) begin
        matched <= matched + PW'(1);
      end
      if (cmd.record && (!have_found || cur_len < shortest_len)) begin
        shortest_len   <= cur_len;
        shortest_start <= left_pos;
        have_found     <= 1'b1;
      end
      if (cmd.shr_upd) begin
        left_pos <= left_pos + PW'(1);
        // The restored count becomes positive, so the byte is missing again.
        if (!need_val[CW-1]) begin
          matched <= matched - PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.found      <= have_found;
      result.best_start <= have_found ? 10'(shortest_start) : 10'd0;
      result.best_len   <= have_found ? 11'(shortest_len) : 11'd0;
      result.status     <= status;
    end
  end

endmodule

FILE: design/minimum_covering_window.sv
// ----------------------------------------------------------------------------
// minimum_covering_window: shortest source window covering a target multiset
// Streams target bytes then source bytes and reports, for every item, the
// shortest source window found so far that contains every target byte.
// ----------------------------------------------------------------------------
// Send the target bytes first (kind target), then the source bytes (kind
// source); a clear item restarts the search. Every item returns exactly one
// result with found, the start and length of the shortest covering window so
// far, and a status code: late target bytes and bytes beyond MAX_LEN are
// dropped and flagged. Symbols are reduced modulo ALPHABET. An item holds the
// block from its transfer until its result is loaded: a target item passes
// through decode, count update and result load, a clear or ignored item
// through decode and result load, and a source byte through decode, count
// update, a check and result load, plus one shrink pass for every byte that
// drops out of the left edge of the window. A shrink pass reads the window
// buffer and then the need count memory, each with a registered read.
// The result sits in an output register, so the next item can be taken while
// a result still waits for its transfer.
// There is no clearing pass after reset: the need counts carry one valid bit
// per symbol, cleared at once by reset or by a clear item.
module minimum_covering_window #(
  parameter int MAX_LEN  = 1024,
  parameter int ALPHABET = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  mcw_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output mcw_pkg::result_t result
);

  // Command and status groups between the sequencer and the datapath.
  mcw_pkg::cmd_t cmd;
  mcw_pkg::sts_t sts;

  mcw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mcw_dpath #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule
